@@ hdl/tcd_pkg.sv @@
// ----------------------------------------------------------------------------
// Trilinear charge deposit package
// Shared constants, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package tcd_pkg;

  localparam int GridN     = 16;
  localparam int IdxW      = 12;
  localparam int AxisW     = $clog2(GridN);
  localparam int CellCount = GridN * GridN * GridN;
  localparam int DepthW    = $clog2(CellCount);
  localparam int CellW     = 48;
  localparam int PosW      = 32;
  localparam int InvW      = 24;
  localparam int WeightW   = 32;
  localparam int FracW     = 16;

  typedef enum logic [1:0] {
    OP_DEPOSIT    = 2'd0,
    OP_READ       = 2'd1,
    OP_READ_CLEAR = 2'd2,
    OP_UNUSED     = 2'd3
  } op_t;

  localparam logic [1:0] REG_INV_X = 2'd0;
  localparam logic [1:0] REG_INV_Y = 2'd1;
  localparam logic [1:0] REG_INV_Z = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic       load;
    logic       locate;
    logic       weights;
    logic       mem_rd;
    logic       mem_wr;
    logic       rd_index;
    logic       clear_wr;
    logic       calc;
    logic [2:0] corner;
    logic       capture;
  } tcd_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic outside;
    logic idx_bad;
  } tcd_stat_t;

endpackage

`default_nettype wire

@@ hdl/tcd_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output      logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

@@ hdl/tcd_datapath.sv @@
// ----------------------------------------------------------------------------
// Trilinear charge deposit datapath
// Holds the operand registers, computes node weights and corner charges,
// and runs read-modify-write accesses into the grid memory.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_datapath
  import tcd_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire tcd_cmd_t                   cmd,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_sel,
  input  wire logic [InvW-1:0]            cfg_data,
  input  wire logic [PosW-1:0]            pos_x,
  input  wire logic [PosW-1:0]            pos_y,
  input  wire logic [PosW-1:0]            pos_z,
  input  wire logic signed [WeightW-1:0]  weight,
  input  wire logic [IdxW-1:0]            cell_index,
  output      tcd_stat_t                  stat,
  output      logic signed [CellW-1:0]    rd_value
);

  logic [InvW-1:0] inv_x, inv_y, inv_z;
  logic [PosW-1:0] px, py, pz;
  logic signed [WeightW-1:0] w;
  logic [IdxW-1:0] ridx;
  logic [PosW+InvW-1:0] nx, ny, nz;
  logic [AxisW-1:0] bx, by, bz;
  logic [FracW:0] sx0, sx1, sy0, sy1, sz0, sz1;
  logic outside;
  logic [FracW:0] sxy;
  logic [FracW:0] sxyz;
  logic signed [CellW-1:0] charge;
  logic [DepthW-1:0] addr, caddr;
  logic we;
  logic [CellW-1:0] wdata, rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_x <= InvW'(65536);
      inv_y <= InvW'(65536);
      inv_z <= InvW'(65536);
    end else if (cfg_we) begin
      unique case (cfg_sel)
        REG_INV_X: inv_x <= cfg_data;
        REG_INV_Y: inv_y <= cfg_data;
        REG_INV_Z: inv_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Load, then locate (three multipliers), then weights.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px <= pos_x;
      py <= pos_y;
      pz <= pos_z;
      w <= weight;
      ridx <= cell_index;
    end
    if (cmd.locate) begin
      nx <= px * inv_x;
      ny <= py * inv_y;
      nz <= pz * inv_z;
    end
    if (cmd.weights) begin
      bx <= nx[32 +: AxisW];
      by <= ny[32 +: AxisW];
      bz <= nz[32 +: AxisW];
      sx1 <= {1'b0, nx[16 +: FracW]};
      sy1 <= {1'b0, ny[16 +: FracW]};
      sz1 <= {1'b0, nz[16 +: FracW]};
      sx0 <= (FracW+1)'(65536) - {1'b0, nx[16 +: FracW]};
      sy0 <= (FracW+1)'(65536) - {1'b0, ny[16 +: FracW]};
      sz0 <= (FracW+1)'(65536) - {1'b0, nz[16 +: FracW]};
      outside <= (nx[PosW+InvW-1:32] > (PosW+InvW-32)'(GridN - 2)) ||
                 (ny[PosW+InvW-1:32] > (PosW+InvW-32)'(GridN - 2)) ||
                 (nz[PosW+InvW-1:32] > (PosW+InvW-32)'(GridN - 2));
    end
  end

  assign stat.outside = outside;
  assign stat.idx_bad = (32'(ridx) >= 32'(CellCount));

  // Corner charge pipeline: sxy, sxyz, charge, one register per product.
  logic [33:0] p1;
  logic [33:0] p2;
  logic signed [WeightW+FracW+1:0] p3;
  always_comb begin
    p1 = (cmd.corner[2] ? sx1 : sx0) * (cmd.corner[1] ? sy1 : sy0) + 34'd32768;
    p2 = sxy * (cmd.corner[0] ? sz1 : sz0) + 34'd32768;
    p3 = w * $signed({1'b0, sxyz}) + (WeightW+FracW+2)'(32768);
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      sxy <= p1[16 +: FracW+1];
    end
    sxyz <= p2[16 +: FracW+1];
    charge <= CellW'(p3 >>> 16);
    caddr <= DepthW'({bz + AxisW'(cmd.corner[0]), by + AxisW'(cmd.corner[1]),
                      bx + AxisW'(cmd.corner[2])});
  end

  // Saturating add of the charge onto the read cell, or a zero write when clearing.
  logic signed [CellW:0] sum;
  always_comb begin
    sum = {rdata[CellW-1], rdata} + {charge[CellW-1], charge};
    if (sum[CellW] != sum[CellW-1]) begin
      wdata = sum[CellW] ? {1'b1, {(CellW-1){1'b0}}} : {1'b0, {(CellW-1){1'b1}}};
    end else begin
      wdata = sum[CellW-1:0];
    end
    if (cmd.clear_wr) begin
      wdata = '0;
    end
    addr = cmd.rd_index ? ridx[DepthW-1:0] : caddr;
    we = cmd.mem_wr;
  end

  tcd_ram #(.Width(CellW), .Depth(CellCount)) u_grid (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_value <= rdata;
    end
  end

endmodule

`default_nettype wire

@@ hdl/tcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// Trilinear charge deposit controller
// Sequences the locate, weight and per-corner read-modify-write steps, the
// index reads, the grid clearing sweep, and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_ctrl
  import tcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [1:0] op,
  input  wire tcd_stat_t  stat,
  output      tcd_cmd_t   cmd,
  output      logic [DepthW-1:0] clr_addr,
  output      logic       clr_we,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic       out_status,
  output      logic       out_from_mem
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOC, S_WGT, S_CHK, S_RD, S_WAIT, S_CALC, S_RMW,
    S_RIDX, S_RDATA, S_DONE
  } state_t;

  state_t state;
  logic [1:0] op_q;
  logic [2:0] corner;
  logic [2:0] step;
  logic [DepthW:0] clr;

  // Corner pipeline per corner: sxy, sxyz, charge and address, read,
  // read data, write.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      out_valid <= 1'b0;
      out_status <= 1'b0;
      out_from_mem <= 1'b0;
      corner <= '0;
      step <= '0;
      op_q <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (DepthW+1)'(CellCount)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op_q <= op;
            priority if (op == OP_DEPOSIT) begin
              state <= S_LOC;
            end else if (op == OP_READ || op == OP_READ_CLEAR) begin
              state <= S_RIDX;
            end else begin
              out_valid <= 1'b1;
              out_status <= 1'b0;
              out_from_mem <= 1'b0;
            end
          end
        end
        S_LOC: state <= S_WGT;
        S_WGT: state <= S_CHK;
        S_CHK: begin
          if (stat.outside) begin
            state <= S_DONE;
            out_status <= 1'b1;
          end else begin
            state <= S_CALC;
            corner <= '0;
            step <= '0;
            out_status <= 1'b0;
          end
        end
        S_CALC: begin
          step <= step + 1'b1;
          if (step == 3'd2) begin
            state <= S_RD;
          end
        end
        S_RD: state <= S_WAIT;
        S_WAIT: state <= S_RMW;
        S_RMW: begin
          corner <= corner + 1'b1;
          step <= '0;
          state <= (corner == 3'd7) ? S_DONE : S_CALC;
        end
        S_RIDX: begin
          if (stat.idx_bad) begin
            out_status <= 1'b1;
            state <= S_DONE;
          end else begin
            out_status <= 1'b0;
            state <= S_RDATA;
          end
        end
        S_RDATA: state <= S_DONE;
        S_DONE: begin
          out_valid <= 1'b1;
          out_from_mem <= (op_q != OP_DEPOSIT) && !out_status;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign clr_addr = clr[DepthW-1:0];
  assign clr_we = (state == S_CLEAR);

  always_comb begin
    cmd = '0;
    cmd.corner = corner;
    cmd.load = (state == S_IDLE);
    cmd.locate = (state == S_LOC);
    cmd.weights = (state == S_WGT);
    cmd.calc = (state == S_CALC) && (step == 3'd0);
    cmd.mem_rd = (state == S_RD) || (state == S_RIDX);
    cmd.rd_index = (state == S_RIDX) || (state == S_RDATA);
    cmd.mem_wr = (state == S_RMW) ||
                 ((state == S_RDATA) && (op_q == OP_READ_CLEAR));
    cmd.clear_wr = (state == S_RDATA);
    cmd.capture = (state == S_RDATA);
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("item accepted while busy");
  a_corner_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_RMW && corner == 3'd7) |=> (state == S_DONE))
    else $error("corner sequence did not end");
  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> out_valid) else $error("result not raised");
`endif

endmodule

`default_nettype wire

@@ hdl/trilinear_charge_deposit.sv @@
// ----------------------------------------------------------------------------
// Trilinear charge deposit
// Cloud-in-cell deposition of particle charge onto a 16x16x16 grid.
// ----------------------------------------------------------------------------
// After reset the block clears the grid memory, one cell per cycle, before it
// accepts an item. A deposit locates the base node, then for each corner forms
// the weight products and runs a read-modify-write of the single-port grid
// memory, and then raises the result; a base node outside the grid skips the
// corner steps. A read returns the indexed cell.
`default_nettype none

module trilinear_charge_deposit
  import tcd_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [InvW-1:0]           cfg_data,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic [1:0]                op,
  input  wire logic [PosW-1:0]           pos_x,
  input  wire logic [PosW-1:0]           pos_y,
  input  wire logic [PosW-1:0]           pos_z,
  input  wire logic signed [WeightW-1:0] weight,
  input  wire logic [IdxW-1:0]           cell_index,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic                      status,
  output      logic signed [CellW-1:0]   cell_value
);

  tcd_cmd_t cmd, cmd_mux;
  tcd_stat_t stat;
  logic [DepthW-1:0] clr_addr;
  logic clr_we;
  logic from_mem;
  logic signed [CellW-1:0] rd_value;

  tcd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .stat(stat), .cmd(cmd), .clr_addr(clr_addr), .clr_we(clr_we),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(status),
    .out_from_mem(from_mem)
  );

  // The clearing sweep reuses the read-index path with a zero write.
  logic [IdxW-1:0] idx_mux;
  always_comb begin
    cmd_mux = cmd;
    idx_mux = cell_index;
    if (clr_we) begin
      cmd_mux = '0;
      cmd_mux.load = 1'b1;
      cmd_mux.rd_index = 1'b1;
      cmd_mux.mem_wr = 1'b1;
      cmd_mux.clear_wr = 1'b1;
      idx_mux = IdxW'(clr_addr);
    end
  end

  // During the sweep the index register holds the sweep address of the previous
  // cycle, so the sweep counter runs one address past the last cell.
  tcd_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd_mux), .cfg_we(cfg_we), .cfg_sel(cfg_index),
    .cfg_data(cfg_data), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .weight(weight), .cell_index(idx_mux), .stat(stat), .rd_value(rd_value)
  );

  assign cell_value = from_mem ? rd_value : '0;

endmodule

`default_nettype wire

@@ tb/sv/trilinear_charge_deposit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Trilinear charge deposit testbench
// Drives deposits, reads and read-and-clear items through the valid/ready
// channels. Where the directed table gives no result, a local model of the
// charge grid predicts it. The table opens the run, and three phases of random
// items follow. Each phase has its own inverse cell lengths and idle pattern.
// ----------------------------------------------------------------------------
module trilinear_charge_deposit_test;
  import tcd_pkg::*;

  localparam int WatchdogLimit = 30000;
  localparam int NodeMax       = GridN - 2;

  typedef struct {
    op_t                        op;
    logic [PosW-1:0]            px;
    logic [PosW-1:0]            py;
    logic [PosW-1:0]            pz;
    logic signed [WeightW-1:0]  w;
    logic [IdxW-1:0]            idx;
  } particle_item_t;

  typedef struct {
    logic              status;
    logic [CellW-1:0]  value;
  } cell_result_t;

  typedef struct {
    particle_item_t  item;
    bit              typed;
    cell_result_t    res;
  } directed_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [1:0]                cfg_index = '0;
  logic [InvW-1:0]           cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                op = OP_DEPOSIT;
  logic [PosW-1:0]           pos_x = '0;
  logic [PosW-1:0]           pos_y = '0;
  logic [PosW-1:0]           pos_z = '0;
  logic signed [WeightW-1:0] weight = '0;
  logic [IdxW-1:0]           cell_index = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      status;
  logic signed [CellW-1:0]   cell_value;

  longint         charge_cells [CellCount];
  logic [InvW-1:0] inv_len [3];
  cell_result_t   pending_results [$];
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  int             errors = 0;
  int             results_seen = 0;
  int             deposits_sent = 0;
  int             dropped_seen = 0;
  int             reads_sent = 0;
  int             stall_count = 0;
  int             last_base = 0;

  trilinear_charge_deposit dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Splits one position into base node and Q0.16 fraction.
  function automatic void locate_axis(input logic [PosW-1:0] p, input logic [InvW-1:0] inv,
                                      output longint node, output longint frac);
    longint unsigned n;
    n = longint'(p) * longint'(inv);
    node = longint'(n >> 32);
    frac = longint'((n >> 16) & 64'hFFFF);
  endfunction

  function automatic cell_result_t deposit_charge(input particle_item_t it);
    cell_result_t r;
    longint bx, by, bz, fx, fy, fz, sxy, sxyz, q, sum;
    longint sx [2];
    longint sy [2];
    longint sz [2];
    int cell_idx;
    r.status = 1'b0;
    r.value = '0;
    case (it.op)
      OP_DEPOSIT: begin
        locate_axis(it.px, inv_len[REG_INV_X], bx, fx);
        locate_axis(it.py, inv_len[REG_INV_Y], by, fy);
        locate_axis(it.pz, inv_len[REG_INV_Z], bz, fz);
        if (bx > NodeMax || by > NodeMax || bz > NodeMax) begin
          r.status = 1'b1;
          return r;
        end
        last_base = int'(bx + by * GridN + bz * GridN * GridN);
        sx[0] = 65536 - fx; sx[1] = fx;
        sy[0] = 65536 - fy; sy[1] = fy;
        sz[0] = 65536 - fz; sz[1] = fz;
        for (int a = 0; a < 2; a++) begin
          for (int b = 0; b < 2; b++) begin
            sxy = (sx[a] * sy[b] + 32768) >>> 16;
            for (int c = 0; c < 2; c++) begin
              sxyz = (sxy * sz[c] + 32768) >>> 16;
              q = ((longint'(it.w) * sxyz) + 32768) >>> 16;
              cell_idx = int'((bx + a) + (by + b) * GridN + (bz + c) * GridN * GridN);
              sum = charge_cells[cell_idx] + q;
              if (sum > 64'sh7FFF_FFFF_FFFF) sum = 64'sh7FFF_FFFF_FFFF;
              if (sum < -64'sh8000_0000_0000) sum = -64'sh8000_0000_0000;
              charge_cells[cell_idx] = sum;
            end
          end
        end
      end
      OP_READ, OP_READ_CLEAR: begin
        if (int'(it.idx) >= CellCount) begin
          r.status = 1'b1;
        end else begin
          r.value = charge_cells[it.idx][CellW-1:0];
          if (it.op == OP_READ_CLEAR) charge_cells[it.idx] = 0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic write_inv(input logic [1:0] index, input logic [InvW-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    if (index <= REG_INV_Z) inv_len[index] = value;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Offers one item, with random idle cycles first, and records the
  // expected result at acceptance.
  task automatic send_item(input particle_item_t it, input bit typed, input cell_result_t typed_res);
    cell_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= it.op;
    pos_x <= it.px;
    pos_y <= it.py;
    pos_z <= it.pz;
    weight <= it.w;
    cell_index <= it.idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = deposit_charge(it);
    if (typed) r = typed_res;
    pending_results.push_back(r);
    if (it.op == OP_DEPOSIT) deposits_sent++;
    else if (it.op != OP_UNUSED) reads_sent++;
  endtask

  function automatic particle_item_t random_item();
    particle_item_t it;
    int pick;
    longint lim [3];
    int offs;
    pick = $urandom_range(99);
    it.px = $urandom();
    it.py = $urandom();
    it.pz = $urandom();
    it.w = $urandom();
    it.idx = IdxW'($urandom_range(CellCount - 1));
    it.op = OP_DEPOSIT;
    if ($urandom_range(2) == 0) it.w = $signed($urandom_range(20'hFFFFF)) - 32'sh80000;
    if (pick < 55) begin
      for (int k = 0; k < 3; k++) begin
        lim[k] = (inv_len[k] == 0) ? 64'hFFFF_FFFF
               : ((longint'(NodeMax + 1) << 32) - 1) / longint'(inv_len[k]);
        if (lim[k] > 64'hFFFF_FFFF) lim[k] = 64'hFFFF_FFFF;
      end
      it.px = PosW'(longint'($urandom()) % (lim[0] + 1));
      it.py = PosW'(longint'($urandom()) % (lim[1] + 1));
      it.pz = PosW'(longint'($urandom()) % (lim[2] + 1));
    end else if (pick < 80) begin
      it.op = ($urandom_range(1) == 0) ? OP_READ : OP_READ_CLEAR;
      offs = ($urandom_range(1) ? 1 : 0) + ($urandom_range(1) ? GridN : 0)
           + ($urandom_range(1) ? GridN * GridN : 0);
      if ($urandom_range(3) != 0) it.idx = IdxW'((last_base + offs) % CellCount);
    end else if (pick >= 92) begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  always @(posedge clk) begin
    cell_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (status) dropped_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0b cell_value=%0d", $time, status, cell_value);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0b actual %0b", $time, want.status, status);
          errors++;
        end
        if (cell_value !== want.value) begin
          $display("%0t: cell_value expected %0d actual %0d", $time,
                   $signed(want.value), cell_value);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
    end
    if (stall_count >= WatchdogLimit) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, pending_results.size());
      $display("** trilinear_charge_deposit: FAILED **");
      $finish;
    end
  end

  initial begin
    directed_row_t dir [$];
    particle_item_t it;
    cell_result_t none;
    none.status = 1'b0;
    none.value = '0;
    for (int i = 0; i < CellCount; i++) charge_cells[i] = 0;
    for (int k = 0; k < 3; k++) inv_len[k] = 24'h010000;

    dir.push_back('{'{OP_READ, 32'h0, 32'h0, 32'h0, 32'sh0, 12'd0}, 1'b1, '{1'b0, 48'h0}});
    dir.push_back('{'{OP_READ_CLEAR, '1, '1, '1, -32'sh1, 12'hFFF}, 1'b1, '{1'b0, 48'h0}});
    dir.push_back('{'{OP_UNUSED, '1, '1, '1, 32'sh7FFFFFFF, 12'hFFF}, 1'b1, '{1'b0, 48'h0}});
    dir.push_back('{'{OP_DEPOSIT, 32'h000F_0000, 32'h0, 32'h0, 32'sh10000, 12'd0}, 1'b1,
                    '{1'b1, 48'h0}});
    dir.push_back('{'{OP_DEPOSIT, 32'h0, 32'h0, 32'h000F_0000, 32'sh10000, 12'd0}, 1'b1,
                    '{1'b1, 48'h0}});
    dir.push_back('{'{OP_DEPOSIT, '1, '1, '1, -32'sh80000000, 12'hFFF}, 1'b1, '{1'b1, 48'h0}});
    dir.push_back('{'{OP_DEPOSIT, 32'h0, 32'h0, 32'h0, 32'sh10000, 12'hFFF}, 1'b0, none});
    dir.push_back('{'{OP_READ, '1, '1, '1, 32'sh0, 12'd0}, 1'b1, '{1'b0, 48'h10000}});
    dir.push_back('{'{OP_READ_CLEAR, 32'h0, 32'h0, 32'h0, 32'sh0, 12'd0}, 1'b1,
                    '{1'b0, 48'h10000}});
    dir.push_back('{'{OP_READ, 32'h0, 32'h0, 32'h0, 32'sh0, 12'd0}, 1'b1, '{1'b0, 48'h0}});
    dir.push_back('{'{OP_DEPOSIT, 32'h000E_8000, 32'h000E_8000, 32'h000E_8000,
                      32'sh7FFFFFFF, 12'd0}, 1'b0, none});
    dir.push_back('{'{OP_DEPOSIT, 32'h000E_FFFF, 32'h000E_FFFF, 32'h000E_FFFF,
                      -32'sh80000000, 12'd0}, 1'b0, none});
    dir.push_back('{'{OP_DEPOSIT, 32'h000E_0001, 32'h0000_FFFF, 32'h000E_4000,
                      -32'sh1, 12'd0}, 1'b0, none});
    dir.push_back('{'{OP_READ, 32'h0, 32'h0, 32'h0, 32'sh0, 12'd3822}, 1'b0, none});
    dir.push_back('{'{OP_READ_CLEAR, 32'h0, 32'h0, 32'h0, 32'sh0, 12'hFFF}, 1'b0, none});
    dir.push_back('{'{OP_READ, 32'h0, 32'h0, 32'h0, 32'sh0, 12'hFFF}, 1'b1, '{1'b0, 48'h0}});
    dir.push_back('{'{OP_READ_CLEAR, 32'h0, 32'h0, 32'h0, 32'sh0, 12'd3822}, 1'b0, none});
    dir.push_back('{'{OP_READ, 32'h0, 32'h0, 32'h0, 32'sh0, 12'd3823}, 1'b0, none});

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_inv(REG_INV_X, 24'h010000);
    write_inv(REG_INV_Y, 24'h010000);
    write_inv(REG_INV_Z, 24'h010000);
    write_inv(2'd3, 24'hFFFFFF);
    cfg_we <= 1'b0;
    @(posedge clk);

    foreach (dir[i]) send_item(dir[i].item, dir[i].typed, dir[i].res);

    for (int phase = 0; phase < 3; phase++) begin
      in_valid <= 1'b0;
      @(posedge clk);
      wait_drained();
      repeat (60) @(posedge clk);
      case (phase)
        0: begin
          write_inv(REG_INV_X, 24'h000000);
          write_inv(REG_INV_Y, 24'hFFFFFF);
          write_inv(REG_INV_Z, 24'h00C000);
        end
        1: begin
          write_inv(REG_INV_X, InvW'($urandom_range(24'h8000, 24'h40000)));
          write_inv(REG_INV_Y, 24'h010000);
          write_inv(REG_INV_Z, InvW'($urandom_range(24'h8000, 24'h40000)));
        end
        default: begin
          write_inv(REG_INV_X, 24'h010000);
          write_inv(REG_INV_Y, 24'h000000);
          write_inv(REG_INV_Z, 24'h018000);
        end
      endcase
      cfg_we <= 1'b0;
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 65 : 0;
      recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 19 : 0;
      for (int n = 0; n < 145; n++) begin
        if (phase == 2 && n == 70) begin
          in_valid <= 1'b0;
          @(posedge clk);
          wait_drained();
        end
        it = random_item();
        send_item(it, 1'b0, none);
      end
    end
    in_valid <= 1'b0;
    recv_idle_pct = 0;
    wait_drained();
    repeat (60) @(posedge clk);

    $display("Covered %0d deposits and %0d reads; %0d results checked, %0d flagged outside.",
             deposits_sent, reads_sent, results_seen, dropped_seen);
    $display("Inverse cell lengths ran at zero, unity, fractional and full scale.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("** trilinear_charge_deposit: PASSED **");
    end else begin
      $display("** trilinear_charge_deposit: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/tcd_pkg.sv
hdl/tcd_ram.sv
hdl/tcd_datapath.sv
hdl/tcd_ctrl.sv
hdl/trilinear_charge_deposit.sv
tb/sv/trilinear_charge_deposit_test.sv
